@@ sv/i2crmv_pkg.sv @@
// Shared types, constants and codes of the I2C register master.
`default_nettype none
package i2crmv_pkg;

    localparam int RETRY_GAP_TICKS = 1024;
    localparam int ACK_POLL_LIMIT  = 5;
    localparam int GAP_W           = $clog2(RETRY_GAP_TICKS + 1);

    localparam int DEV_W  = 7;
    localparam int ATT_W  = 3;
    localparam int CNT_W  = 3;
    localparam int BYTE_W = 8;

    localparam logic [DEV_W-1:0] DEV_ADDR_RST = 7'd86;
    localparam logic [ATT_W-1:0] MAX_ATT_RST  = 3'd3;

    typedef enum logic [0:0] {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_MAX_ATTEMPTS   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_VERIFY = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_START = 4'd1,
        OP_WBYTE = 4'd2,
        OP_ACK   = 4'd3,
        OP_STOP  = 4'd4,
        OP_PAUSE = 4'd5,
        OP_RBYTE = 4'd6,
        OP_NACK  = 4'd7,
        OP_GAP   = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        BSEL_NONE   = 3'd0,
        BSEL_ADDR_W = 3'd1,
        BSEL_REG    = 3'd2,
        BSEL_DATA   = 3'd3,
        BSEL_ADDR_R = 3'd4
    } t_bsel;

    typedef enum logic [21:0] {
        PH_IDLE    = 22'h000001,
        PH_WSTART  = 22'h000002,
        PH_WADDR   = 22'h000004,
        PH_WACK0   = 22'h000008,
        PH_WREG    = 22'h000010,
        PH_WACK1   = 22'h000020,
        PH_WDATA   = 22'h000040,
        PH_WACK2   = 22'h000080,
        PH_WSTOP   = 22'h000100,
        PH_PAUSE   = 22'h000200,
        PH_RSTART  = 22'h000400,
        PH_RADDR   = 22'h000800,
        PH_RACK0   = 22'h001000,
        PH_RREG    = 22'h002000,
        PH_RACK1   = 22'h004000,
        PH_RRSTART = 22'h008000,
        PH_RADDR_R = 22'h010000,
        PH_RACK2   = 22'h020000,
        PH_RBYTE   = 22'h040000,
        PH_NACK    = 22'h080000,
        PH_RSTOP   = 22'h100000,
        PH_GAP     = 22'h200000
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [CNT_W-1:0]    unit_cnt;
        logic [CNT_W-1:0]    bit_cnt;
        logic [BYTE_W-1:0]   shift_byte;
        logic [CNT_W-1:0]    ack_polls;
        logic [ATT_W-1:0]    attempts_left;
        logic [GAP_W-1:0]    gap_cnt;
        t_action             act;
        logic [BYTE_W-1:0]   reg_addr;
        logic [BYTE_W-1:0]   wr_data;
        logic [BYTE_W-1:0]   read_result;
        logic                verify_ok;
        logic                scl;
        logic                sda;
    } t_state;

    typedef struct packed {
        logic                scl_level;
        logic                sda_level;
        logic                busy_res;
        logic                done_res;
        logic [BYTE_W-1:0]   read_byte;
        logic                verify_ok;
    } t_result;

    typedef struct packed {
        logic [DEV_W-1:0]    device_address;
        logic [ATT_W-1:0]    max_attempts;
    } t_cfg;

    localparam t_state STATE_RST = '{
        phase: PH_IDLE, unit_cnt: '0, bit_cnt: '0, shift_byte: '0, ack_polls: '0,
        attempts_left: '0, gap_cnt: '0, act: ACT_TICK, reg_addr: '0, wr_data: '0,
        read_result: '0, verify_ok: 1'b0, scl: 1'b1, sda: 1'b1
    };

endpackage
`default_nettype wire

@@ sv/i2crmv_if.sv @@
// Handshake channels of the I2C register master: command, result and config.
`default_nettype none
interface i2crmv_in_if import i2crmv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [BYTE_W-1:0] reg_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              sda_in;
    modport source (output valid, action, reg_addr, wr_data, sda_in, input ready);
    modport sink   (input valid, action, reg_addr, wr_data, sda_in, output ready);
endinterface

interface i2crmv_out_if import i2crmv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              verify_ok;
    modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    verify_ok, input ready);
    modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_byte,
                    verify_ok, output ready);
endinterface

interface i2crmv_cfg_if import i2crmv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [0:0]       index;
    logic [DEV_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/i2crmv_seq.sv @@
// Bus sequencer: next state and result of one bus time unit.
`default_nettype none
module i2crmv_seq import i2crmv_pkg::*; (
    input  t_state            i_state,
    input  t_cfg              i_cfg,
    input  logic [1:0]        i_action,
    input  logic [BYTE_W-1:0] i_reg_addr,
    input  logic [BYTE_W-1:0] i_wr_data,
    input  logic              i_sda_in,
    output t_state            o_next,
    output t_result           o_res
);

    function automatic t_state enter(input t_state st, input t_phase p);
        t_state r;
        r          = st;
        r.phase    = p;
        r.unit_cnt = '0;
        r.bit_cnt  = '0;
        r.ack_polls = '0;
        r.gap_cnt  = '0;
        return r;
    endfunction

    function automatic t_op phase_op(input t_phase p);
        case (p)
            PH_WSTART, PH_RSTART, PH_RRSTART:                      phase_op = OP_START;
            PH_WADDR, PH_WREG, PH_WDATA, PH_RADDR, PH_RREG, PH_RADDR_R: phase_op = OP_WBYTE;
            PH_WACK0, PH_WACK1, PH_WACK2, PH_RACK0, PH_RACK1, PH_RACK2: phase_op = OP_ACK;
            PH_WSTOP, PH_RSTOP:                                    phase_op = OP_STOP;
            PH_PAUSE:                                              phase_op = OP_PAUSE;
            PH_RBYTE:                                              phase_op = OP_RBYTE;
            PH_NACK:                                               phase_op = OP_NACK;
            PH_GAP:                                                phase_op = OP_GAP;
            default:                                               phase_op = OP_IDLE;
        endcase
    endfunction

    function automatic t_bsel phase_bsel(input t_phase p);
        case (p)
            PH_WADDR, PH_RADDR: phase_bsel = BSEL_ADDR_W;
            PH_WREG, PH_RREG:   phase_bsel = BSEL_REG;
            PH_WDATA:           phase_bsel = BSEL_DATA;
            PH_RADDR_R:         phase_bsel = BSEL_ADDR_R;
            default:            phase_bsel = BSEL_NONE;
        endcase
    endfunction

    t_state            s;
    t_op               op;
    logic [BYTE_W-1:0] tx;
    logic [CNT_W-1:0]  uc;
    logic [CNT_W-1:0]  polls;
    logic [GAP_W-1:0]  gap;
    logic [ATT_W-1:0]  att;
    logic              scl;
    logic              sda;
    logic              fin;
    logic              rel;
    logic              busy;
    logic              done;

    always_comb begin
        s     = i_state;
        op    = OP_IDLE;
        tx    = '0;
        uc    = '0;
        polls = '0;
        gap   = '0;
        att   = '0;
        fin   = 1'b0;
        rel   = 1'b0;
        busy  = 1'b0;
        done  = 1'b0;
        scl   = s.scl;
        sda   = s.sda;

        // command latch on an idle unit
        if (s.phase == PH_IDLE && t_action'(i_action) != ACT_TICK) begin
            s.act           = t_action'(i_action);
            s.reg_addr      = i_reg_addr;
            s.wr_data       = i_wr_data;
            s.attempts_left = i_cfg.max_attempts;
            s.shift_byte    = '0;
            s = enter(s, (t_action'(i_action) == ACT_READ) ? PH_RSTART : PH_WSTART);
        end

        if (s.phase != PH_IDLE) begin
            busy = 1'b1;
            op   = phase_op(s.phase);
            uc   = s.unit_cnt;
            case (phase_bsel(s.phase))
                BSEL_ADDR_W: tx = {i_cfg.device_address, 1'b0};
                BSEL_REG:    tx = s.reg_addr;
                BSEL_DATA:   tx = s.wr_data;
                BSEL_ADDR_R: tx = {i_cfg.device_address, 1'b1};
                default:     tx = '0;
            endcase

            case (op)
                OP_START: begin
                    if (uc == 3'd0)      sda = 1'b1;
                    else if (uc == 3'd1) scl = 1'b1;
                    else if (uc == 3'd2) sda = 1'b0;
                    else begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                    s.unit_cnt = uc + 3'd1;
                end
                OP_WBYTE: begin
                    if (uc == 3'd0) begin
                        sda        = tx[3'd7 - s.bit_cnt];
                        s.unit_cnt = 3'd1;
                    end else if (uc == 3'd1 || uc == 3'd2) begin
                        scl        = 1'b1;
                        s.unit_cnt = uc + 3'd1;
                    end else begin
                        scl = 1'b0;
                        if (s.bit_cnt == 3'd7) begin
                            sda = 1'b1;
                            fin = 1'b1;
                        end else begin
                            s.bit_cnt  = s.bit_cnt + 3'd1;
                            s.unit_cnt = '0;
                        end
                    end
                end
                OP_ACK: begin
                    if (uc == 3'd0) begin
                        sda        = 1'b1;
                        s.unit_cnt = 3'd1;
                    end else if (uc == 3'd1) begin
                        scl        = 1'b1;
                        s.unit_cnt = 3'd2;
                    end else if (uc == 3'd2) begin
                        polls       = s.ack_polls + 3'd1;
                        s.ack_polls = polls;
                        // no ack yet: poll again until the limit, then move on
                        s.unit_cnt  = (i_sda_in && polls < CNT_W'(ACK_POLL_LIMIT))
                                      ? 3'd1 : 3'd3;
                    end else begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (uc == 3'd0)      scl = 1'b0;
                    else if (uc == 3'd1) sda = 1'b0;
                    else begin
                        scl = 1'b1;
                        fin = 1'b1;
                        rel = 1'b1;
                    end
                    s.unit_cnt = uc + 3'd1;
                end
                OP_PAUSE: begin
                    if (uc != 3'd0) fin = 1'b1;
                    s.unit_cnt = uc + 3'd1;
                end
                OP_RBYTE: begin
                    if (uc == 3'd0) begin
                        scl        = 1'b1;
                        s.unit_cnt = 3'd1;
                    end else if (uc == 3'd1) begin
                        s.shift_byte = {s.shift_byte[BYTE_W-2:0], i_sda_in};
                        s.unit_cnt   = 3'd2;
                    end else begin
                        scl = 1'b0;
                        if (s.bit_cnt == 3'd7) begin
                            s.read_result = s.shift_byte;
                            fin           = 1'b1;
                        end else begin
                            s.bit_cnt  = s.bit_cnt + 3'd1;
                            s.unit_cnt = '0;
                        end
                    end
                end
                OP_NACK: begin
                    if (uc == 3'd0)      sda = 1'b1;
                    else if (uc == 3'd1) scl = 1'b1;
                    else if (uc == 3'd3) scl = 1'b0;
                    else if (uc >= 3'd4) begin
                        sda = 1'b1;
                        fin = 1'b1;
                    end
                    s.unit_cnt = uc + 3'd1;
                end
                OP_GAP: begin
                    gap       = s.gap_cnt + GAP_W'(1);
                    s.gap_cnt = gap;
                    if (gap >= GAP_W'(RETRY_GAP_TICKS)) fin = 1'b1;
                end
                default: fin = 1'b1;
            endcase

            s.scl = rel ? 1'b1 : scl;
            s.sda = rel ? 1'b1 : sda;

            if (fin) begin
                case (s.phase)
                    PH_WSTOP: begin
                        if (s.act == ACT_VERIFY) s = enter(s, PH_PAUSE);
                        else begin
                            s    = enter(s, PH_IDLE);
                            done = 1'b1;
                        end
                    end
                    PH_RSTOP: begin
                        if (s.act == ACT_VERIFY) begin
                            if (s.read_result == s.wr_data) begin
                                s.verify_ok = 1'b1;
                                s           = enter(s, PH_IDLE);
                                done        = 1'b1;
                            end else begin
                                att = (s.attempts_left != '0) ? s.attempts_left - 3'd1 : '0;
                                s.attempts_left = att;
                                if (att == '0) begin
                                    s.verify_ok = 1'b0;
                                    s           = enter(s, PH_IDLE);
                                    done        = 1'b1;
                                end else begin
                                    s = enter(s, PH_GAP);
                                end
                            end
                        end else begin
                            s    = enter(s, PH_IDLE);
                            done = 1'b1;
                        end
                    end
                    PH_GAP:  s = enter(s, PH_WSTART);
                    default: s = enter(s, t_phase'(s.phase << 1));
                endcase
            end
        end

        o_next            = s;
        o_res.scl_level   = scl;
        o_res.sda_level   = sda;
        o_res.busy_res    = busy;
        o_res.done_res    = done;
        o_res.read_byte   = s.read_result;
        o_res.verify_ok   = s.verify_ok;
    end

endmodule
`default_nettype wire

@@ sv/i2c_register_master_verify_unit.sv @@
// Top level of the I2C register master with write-verify and register read.
`default_nettype none
// ---------------------------------------------------------------------------
//  Channel   Dir   Modport  Word
//  i_cmd     in    sink     action, reg_addr, wr_data, sda_in (one bus unit)
//  o_res     out   source   scl_level, sda_level, busy_res, done_res,
//                           read_byte, verify_ok (one per command word)
//  i_cfg     in    sink     index (0 device_address, 1 max_attempts), data
//
//  One command word is one bus time unit; it is taken every cycle while i_cmd is
//  ready. The sequencer state and the result word are both registered on accept.
//  Reset (sync, active low): idle, both pins released, address 86, 3 tries.
//  i_cmd.ready is high while the result register is empty or being taken, so a
//  stalled o_res holds the result and stalls i_cmd; config is always ready.
// ---------------------------------------------------------------------------
module i2c_register_master_verify_unit import i2crmv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    i2crmv_in_if.sink  i_cmd,
    i2crmv_out_if.source o_res,
    i2crmv_cfg_if.sink i_cfg
);

    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    t_cfg    r_cfg;
    logic    w_in_ready;
    logic    w_in_acc;

    // result register frees up when downstream takes the word
    assign w_in_ready  = !r_out_valid || o_res.ready;
    assign w_in_acc    = i_cmd.valid && w_in_ready;
    assign i_cmd.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    i2crmv_seq u_seq (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_action   (i_cmd.action),
        .i_reg_addr (i_cmd.reg_addr),
        .i_wr_data  (i_cmd.wr_data),
        .i_sda_in   (i_cmd.sda_in),
        .o_next     (n_state),
        .o_res      (n_res)
    );

    // sequencer state: advances one bus unit per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEV_ADDR_RST;
            r_cfg.max_attempts   <= MAX_ATT_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg.data;
                CFG_MAX_ATTEMPTS:   r_cfg.max_attempts   <= i_cfg.data[ATT_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_res.scl_level;
    assign o_res.sda_level = r_res.sda_level;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.read_byte = r_res.read_byte;
    assign o_res.verify_ok = r_res.verify_ok;

endmodule
`default_nettype wire

@@ tb/tb_i2c_register_master_verify_unit.sv @@
// Self-checking testbench for the I2C register master with write-verify and register read.
`timescale 1ns / 100ps
module tb_i2c_register_master_verify_unit import i2crmv_pkg::*; ();

    localparam int  CLK_HALF    = 10;
    localparam int  RST_CYCLES  = 10;
    localparam int  SETTLE      = 20;          // extra cycles after the last result
    localparam time RUN_LIMIT   = 20_000_000;  // watchdog time, far above the slowest run

    // how the modeled target answers acknowledge polls
    localparam int ACK_CLEAN  = 0;  // always acks at the first poll
    localparam int ACK_FLAKY  = 1;  // misses a poll now and then
    localparam int ACK_ABSENT = 2;  // never acks, master must give up and go on

    // one bus time unit as fed to the master
    typedef struct packed {
        t_action           act;
        logic [BYTE_W-1:0] ra;
        logic [BYTE_W-1:0] wd;
        logic              sin;
    } t_bus_word;

    // sequencer state of the master as the predictor tracks it
    typedef struct packed {
        t_phase            ph;
        t_action           act;
        logic [CNT_W-1:0]  ucnt;
        logic [CNT_W-1:0]  bitn;
        logic [CNT_W-1:0]  polls;
        logic [ATT_W-1:0]  tries;
        logic [BYTE_W-1:0] shreg;
        logic [BYTE_W-1:0] rd_byte;
        logic [BYTE_W-1:0] reg_a;
        logic [BYTE_W-1:0] wdat;
        logic [15:0]       gap;
        logic              vflag;
        logic              scl;
        logic              sda;
    } t_bus_state;

    logic i_clk;
    logic i_rst_n;

    i2crmv_in_if  cmd_if ();
    i2crmv_out_if res_if ();
    i2crmv_cfg_if cfg_if ();

    i2c_register_master_verify_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Register shadow. Only written while nothing is in flight, so the stimulus
    // planner and the accept-side predictor can share it.
    logic [DEV_W-1:0] cfg_dev;
    logic [ATT_W-1:0] cfg_att;

    t_bus_state plan_st;   // planner copy, runs ahead while the queue is filled
    t_bus_state live_st;   // predictor copy, advanced on every accepted word

    t_bus_word bus_unit_q[$];    // words waiting for the driver
    t_result   pin_report_q[$];  // predicted result words, oldest first

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatch_cnt;
    int n_words;

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic t_op op_of(input t_phase p);
        case (p)
            PH_WSTART, PH_RSTART, PH_RRSTART:               return OP_START;
            PH_WADDR, PH_WREG, PH_WDATA,
            PH_RADDR, PH_RREG, PH_RADDR_R:                  return OP_WBYTE;
            PH_WACK0, PH_WACK1, PH_WACK2,
            PH_RACK0, PH_RACK1, PH_RACK2:                   return OP_ACK;
            PH_WSTOP, PH_RSTOP:                             return OP_STOP;
            PH_PAUSE:                                       return OP_PAUSE;
            PH_RBYTE:                                       return OP_RBYTE;
            PH_NACK:                                        return OP_NACK;
            PH_GAP:                                         return OP_GAP;
            default:                                        return OP_IDLE;
        endcase
    endfunction

    function automatic t_bus_state entered(input t_bus_state s, input t_phase p);
        s.ph    = p;
        s.ucnt  = '0;
        s.bitn  = '0;
        s.polls = '0;
        s.gap   = '0;
        return s;
    endfunction

    // One bus unit: takes a command when idle, steps the current operation,
    // returns the pin levels shown during the unit plus the status flags.
    task automatic master_unit(inout t_bus_state s, input t_action a,
                               input logic [BYTE_W-1:0] ra, input logic [BYTE_W-1:0] wd,
                               input logic sin, output t_result r);
        logic             scl;
        logic             sda;
        logic             fin;
        logic             rel;
        logic             bitv;
        logic [CNT_W-1:0] uc;
        logic [BYTE_W-1:0] tx;
        r = '0;
        r.scl_level = s.scl;
        r.sda_level = s.sda;
        if (op_of(s.ph) == OP_IDLE) begin
            s.ph = PH_IDLE;
            if (a != ACT_TICK) begin
                s.act   = a;
                s.reg_a = ra;
                s.wdat  = wd;
                s.tries = cfg_att;
                s.shreg = '0;
                s = entered(s, (a == ACT_READ) ? PH_RSTART : PH_WSTART);
            end
        end
        if (s.ph != PH_IDLE) begin
            r.busy_res = 1'b1;
            scl = s.scl;
            sda = s.sda;
            uc  = s.ucnt;
            fin = 1'b0;
            rel = 1'b0;
            case (s.ph)
                PH_WADDR, PH_RADDR: tx = {cfg_dev, 1'b0};
                PH_WREG, PH_RREG:   tx = s.reg_a;
                PH_WDATA:           tx = s.wdat;
                PH_RADDR_R:         tx = {cfg_dev, 1'b1};
                default:            tx = '0;
            endcase
            bitv = tx[3'd7 - s.bitn];
            case (op_of(s.ph))
                OP_START: begin
                    if (uc == 3'd0) sda = 1'b1;
                    else if (uc == 3'd1) scl = 1'b1;
                    else if (uc == 3'd2) sda = 1'b0;
                    else begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                    s.ucnt = uc + 3'd1;
                end
                OP_WBYTE: begin
                    if (uc == 3'd0) begin
                        sda    = bitv;
                        s.ucnt = 3'd1;
                    end else if (uc == 3'd1 || uc == 3'd2) begin
                        scl    = 1'b1;
                        s.ucnt = uc + 3'd1;
                    end else begin
                        scl = 1'b0;
                        if (s.bitn >= 3'd7) begin
                            sda = 1'b1;
                            fin = 1'b1;
                        end else begin
                            s.bitn = s.bitn + 3'd1;
                            s.ucnt = '0;
                        end
                    end
                end
                OP_ACK: begin
                    if (uc == 3'd0) begin
                        sda    = 1'b1;
                        s.ucnt = 3'd1;
                    end else if (uc == 3'd1) begin
                        scl    = 1'b1;
                        s.ucnt = 3'd2;
                    end else if (uc == 3'd2) begin
                        // high SDA at the poll means no ack yet: poll again until the limit
                        s.polls = s.polls + 3'd1;
                        s.ucnt  = (sin && s.polls < CNT_W'(ACK_POLL_LIMIT)) ? 3'd1 : 3'd3;
                    end else begin
                        scl = 1'b0;
                        fin = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (uc == 3'd0) scl = 1'b0;
                    else if (uc == 3'd1) sda = 1'b0;
                    else begin
                        scl = 1'b1;
                        fin = 1'b1;
                        rel = 1'b1;  // SDA goes high right after the last unit
                    end
                    s.ucnt = uc + 3'd1;
                end
                OP_PAUSE: begin
                    if (uc >= 3'd1) fin = 1'b1;
                    s.ucnt = uc + 3'd1;
                end
                OP_RBYTE: begin
                    if (uc == 3'd0) begin
                        scl    = 1'b1;
                        s.ucnt = 3'd1;
                    end else if (uc == 3'd1) begin
                        s.shreg = {s.shreg[6:0], sin};
                        s.ucnt  = 3'd2;
                    end else begin
                        scl = 1'b0;
                        if (s.bitn >= 3'd7) begin
                            s.rd_byte = s.shreg;
                            fin       = 1'b1;
                        end else begin
                            s.bitn = s.bitn + 3'd1;
                            s.ucnt = '0;
                        end
                    end
                end
                OP_NACK: begin
                    if (uc == 3'd0) sda = 1'b1;
                    else if (uc == 3'd1) scl = 1'b1;
                    else if (uc == 3'd3) scl = 1'b0;
                    else if (uc >= 3'd4) begin
                        sda = 1'b1;
                        fin = 1'b1;
                    end
                    s.ucnt = uc + 3'd1;
                end
                OP_GAP: begin
                    s.gap = s.gap + 16'd1;
                    if (s.gap >= 16'(RETRY_GAP_TICKS)) fin = 1'b1;
                end
                default: fin = 1'b1;
            endcase
            r.scl_level = scl;
            r.sda_level = sda;
            s.scl = scl | rel;
            s.sda = sda | rel;
            if (fin) begin
                case (s.ph)
                    PH_WSTOP: begin
                        if (s.act == ACT_VERIFY) begin
                            s = entered(s, PH_PAUSE);
                        end else begin
                            s = entered(s, PH_IDLE);
                            r.done_res = 1'b1;
                        end
                    end
                    PH_RSTOP: begin
                        if (s.act != ACT_VERIFY) begin
                            s = entered(s, PH_IDLE);
                            r.done_res = 1'b1;
                        end else if (s.rd_byte == s.wdat) begin
                            s.vflag = 1'b1;
                            s = entered(s, PH_IDLE);
                            r.done_res = 1'b1;
                        end else begin
                            // zero tries counts as a single try
                            if (s.tries != '0) s.tries = s.tries - 3'd1;
                            if (s.tries == '0) begin
                                s.vflag = 1'b0;
                                s = entered(s, PH_IDLE);
                                r.done_res = 1'b1;
                            end else begin
                                s = entered(s, PH_GAP);
                            end
                        end
                    end
                    PH_GAP:  s = entered(s, PH_WSTART);
                    default: s = entered(s, t_phase'(s.ph << 1));  // one-hot: next phase
                endcase
            end
        end
        r.read_byte = s.rd_byte;
        r.verify_ok = s.vflag;
    endtask

    // ------------------------------------------------------------------
    // Stimulus planning
    // ------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Queues one command and every bus unit up to its done word. The SDA level
    // of each unit is chosen as the target would drive it, so acks and read
    // data land where the master samples them. mism = leading verify readbacks
    // that miss the written byte.
    task automatic plan_command(input t_action a, input logic [BYTE_W-1:0] ra,
                                input logic [BYTE_W-1:0] wd, input logic [BYTE_W-1:0] rb,
                                input int mism, input int ack_style);
        t_bus_word         w;
        t_result           dummy;
        logic [BYTE_W-1:0] resp;
        int                tries;
        tries = 0;
        resp  = rb;
        w.act = a;
        w.ra  = ra;
        w.wd  = wd;
        do begin
            if (op_of(plan_st.ph) == OP_ACK && plan_st.ucnt == 3'd2) begin
                case (ack_style)
                    ACK_CLEAN:  w.sin = 1'b0;
                    ACK_ABSENT: w.sin = 1'b1;
                    default:    w.sin = ($urandom_range(9) == 0);
                endcase
            end else if (op_of(plan_st.ph) == OP_RBYTE) begin
                if (plan_st.bitn == '0 && plan_st.ucnt == '0 && plan_st.act == ACT_VERIFY) begin
                    resp  = (tries < mism) ? wd ^ 8'($urandom_range(1, 255)) : wd;
                    tries = tries + 1;
                end
                w.sin = resp[3'd7 - plan_st.bitn];
            end else begin
                w.sin = 1'($urandom_range(1));
            end
            master_unit(plan_st, w.act, w.ra, w.wd, w.sin, dummy);
            bus_unit_q.push_back(w);
            n_words = n_words + 1;
            // while busy the command fields are ignored: fill them with noise
            w.act = t_action'($urandom_range(3));
            w.ra  = 8'($urandom_range(255));
            w.wd  = 8'($urandom_range(255));
        end while (plan_st.ph != PH_IDLE);
    endtask

    task automatic wait_drain();
        do @(negedge i_clk);
        while (bus_unit_q.size() != 0 || cmd_if.valid || pin_report_q.size() != 0);
    endtask

    // hold_midway: sender stops halfway until every result is back
    task automatic plan_random_phase(input int target, input int mism_pct, input bit hold_midway);
        int first;
        bit paused;
        first  = n_words;
        paused = 1'b0;
        while (n_words - first < target) begin
            if (hold_midway && !paused && n_words - first >= target / 2) begin
                paused = 1'b1;
                wait_drain();
            end
            plan_command(t_action'($urandom_range(3)), pick_byte(), pick_byte(), pick_byte(),
                         ($urandom_range(99) < mism_pct) ? int'($urandom_range(1, 2)) : 0,
                         ($urandom_range(19) == 0) ? ACK_ABSENT : ACK_FLAKY);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DEV_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS) cfg_dev = val;
        else cfg_att = val[ATT_W-1:0];
    endtask

    // ------------------------------------------------------------------
    // Driver: pops planned words, holds each until taken, and runs the
    // predictor on every word the master accepts.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_bus_word w;
        t_result   want;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                master_unit(live_st, t_action'(cmd_if.action), cmd_if.reg_addr,
                            cmd_if.wr_data, cmd_if.sda_in, want);
                pin_report_q.push_back(want);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (bus_unit_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    w = bus_unit_q.pop_front();
                    cmd_if.valid    <= 1'b1;
                    cmd_if.action   <= w.act;
                    cmd_if.reg_addr <= w.ra;
                    cmd_if.wr_data  <= w.wd;
                    cmd_if.sda_in   <= w.sin;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic note_miss(input string field, input logic [BYTE_W-1:0] want,
                             input logic [BYTE_W-1:0] got);
        mismatch_cnt = mismatch_cnt + 1;
        $display("%0t: %s expected %02h actual %02h", $time, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Monitor: each result word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pin_report_q.size() == 0) begin
                mismatch_cnt = mismatch_cnt + 1;
                $display("%0t: result word with nothing predicted", $time);
            end else begin
                want = pin_report_q.pop_front();
                if (res_if.scl_level !== want.scl_level)
                    note_miss("scl_level", 8'(want.scl_level), 8'(res_if.scl_level));
                if (res_if.sda_level !== want.sda_level)
                    note_miss("sda_level", 8'(want.sda_level), 8'(res_if.sda_level));
                if (res_if.busy_res !== want.busy_res)
                    note_miss("busy_res", 8'(want.busy_res), 8'(res_if.busy_res));
                if (res_if.done_res !== want.done_res)
                    note_miss("done_res", 8'(want.done_res), 8'(res_if.done_res));
                if (res_if.read_byte !== want.read_byte)
                    note_miss("read_byte", want.read_byte, res_if.read_byte);
                if (res_if.verify_ok !== want.verify_ok)
                    note_miss("verify_ok", 8'(want.verify_ok), 8'(res_if.verify_ok));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.action   = ACT_TICK;
        cmd_if.reg_addr = '0;
        cmd_if.wr_data  = '0;
        cmd_if.sda_in   = 1'b1;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_DEVICE_ADDRESS;
        cfg_if.data     = '0;
        cfg_dev         = DEV_ADDR_RST;
        cfg_att         = MAX_ATT_RST;
        live_st         = '0;
        live_st.ph      = PH_IDLE;
        live_st.act     = ACT_TICK;
        live_st.scl     = 1'b1;
        live_st.sda     = 1'b1;
        plan_st         = live_st;
        mismatch_cnt    = 0;
        n_words         = 0;
        tx_idle_pct     = 8;    // sender rarely idles, receiver stalls a lot
        rx_idle_pct     = 73;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset settings (address 86, three tries).
        // Idle ticks show released pins.
        plan_command(ACT_TICK, 8'h00, 8'h00, 8'h00, 0, ACK_CLEAN);
        plan_command(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 0, ACK_CLEAN);
        // plain writes at the byte extremes, one with a target that never acks
        plan_command(ACT_WRITE, 8'h00, 8'h00, 8'h00, 0, ACK_CLEAN);
        plan_command(ACT_WRITE, 8'hFF, 8'hFF, 8'h00, 0, ACK_ABSENT);
        // reads returning all ones and all zeros, repeated start and NACK
        plan_command(ACT_READ, 8'hA5, 8'h00, 8'hFF, 0, ACK_CLEAN);
        plan_command(ACT_READ, 8'h5A, 8'hFF, 8'h00, 0, ACK_FLAKY);
        // verify that matches at once, then one that misses first and waits out the gap
        plan_command(ACT_VERIFY, 8'h12, 8'h34, 8'h00, 0, ACK_CLEAN);
        plan_command(ACT_VERIFY, 8'hC3, 8'h3C, 8'h00, 1, ACK_FLAKY);
        plan_command(ACT_TICK, 8'h00, 8'h00, 8'h00, 0, ACK_CLEAN);
        wait_drain();

        // Address zero, zero tries: a missed readback ends the verify at once.
        write_reg(CFG_DEVICE_ADDRESS, 7'd0);
        write_reg(CFG_MAX_ATTEMPTS, 7'd0);
        plan_random_phase(150, 40, 1'b0);
        wait_drain();

        // Top address, seven tries; sender idles, receiver mostly ready.
        // Halfway the sender holds off until all results are back.
        tx_idle_pct = 73;
        rx_idle_pct = 8;
        write_reg(CFG_DEVICE_ADDRESS, 7'd127);
        write_reg(CFG_MAX_ATTEMPTS, 7'd7);
        plan_random_phase(150, 15, 1'b1);
        wait_drain();

        // Random address, single try, no idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_DEVICE_ADDRESS, 7'($urandom_range(127)));
        write_reg(CFG_MAX_ATTEMPTS, 7'd1);
        plan_random_phase(150, 40, 1'b0);
        wait_drain();

        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_cnt == 0 && pin_report_q.size() == 0) begin
            $display("i2c_register_master_verify_unit regression: pass");
        end else begin
            $display("i2c_register_master_verify_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("i2c_register_master_verify_unit regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
sv/i2crmv_pkg.sv
sv/i2crmv_if.sv
sv/i2crmv_seq.sv
sv/i2c_register_master_verify_unit.sv
tb/tb_i2c_register_master_verify_unit.sv
